/* sv/dual_bank_priority_interrupt_controller_core_assert.svh */
// Assertion macros used by the top level of the interrupt controller.
`ifndef DUAL_BANK_PRIORITY_INTERRUPT_CONTROLLER_CORE_ASSERT_SVH
`define DUAL_BANK_PRIORITY_INTERRUPT_CONTROLLER_CORE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define DBPIC_ASSERT_IMP(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define DBPIC_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

/* sv/dbpic_pkg.sv */
// Package with the payload types, constants and commands of the interrupt controller.
package dbpic_pkg;
	localparam int SRC_MAX = 64;
	localparam int BANK_MAX = 2;
	localparam logic [1:0] REQ_READ = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_LINE = 2'd2;
	localparam logic [1:0] UNIT_GLOBAL = 2'd2;
	localparam logic [7:0] OFF_PEND_HI = 8'h00;
	localparam logic [7:0] OFF_PEND_LO = 8'h04;
	localparam logic [7:0] OFF_MASK_HI = 8'h08;
	localparam logic [7:0] OFF_MASK_LO = 8'h0c;
	localparam logic [7:0] OFF_SET_MASK = 8'h1c;
	localparam logic [7:0] OFF_CLR_MASK = 8'h1d;
	localparam logic [7:0] OFF_VECTOR = 8'he0;
	localparam logic [7:0] VEC_NONE = 8'd24;
	localparam logic [7:0] VEC_BASE = 8'd64;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  unit;
		logic [7:0]  offset;
		logic [31:0] wdata;
		logic [6:0]  line;
		logic        line_level;
	} in_item_t;

	typedef struct packed {
		logic [31:0] rdata;
		logic        bad_access;
		logic [7:0]  cpu_level;
		logic [7:0]  cpu_vector;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the item, compute the read, apply the update
		logic scan_step;  // advance the priority scan by one source of each bank
		logic scan_start; // clear scan accumulators
		logic finish;     // resolve banks and load the result register
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;  // the current scan step is the last one
	} dp_status_t;
endpackage

/* sv/dual_bank_priority_interrupt_controller_core.sv */
// Top level of the two-bank vectored priority interrupt controller.
// Each transfer on the input channel is a bus read, a bus write or an
// interrupt line change, and produces exactly one result transfer carrying
// read data, an error flag and the winning level and vector after the
// rescan. Reads see the state before the item's own rescan. The level bytes
// live in a memory that is read at one source of each bank per cycle, and the
// priority scan is pipelined (one read stage, one compare stage). The block
// handles one item at a time and takes no new item before its result is
// built; input stall is high from acceptance until the result register is
// loaded. A result that waits in the output register does not block the next
// item, but that item's result waits until the register is free, and input
// stays stalled meanwhile.
module dual_bank_priority_interrupt_controller_core #(
	parameter int SOURCES_PER_BANK = dbpic_pkg::SRC_MAX,
	parameter int BANKS = dbpic_pkg::BANK_MAX
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  dbpic_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output dbpic_pkg::out_item_t out_data
);
	import dbpic_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	dbpic_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .status(status)
	);

	dbpic_datapath #(.SOURCES_PER_BANK(SOURCES_PER_BANK), .BANKS(BANKS)) u_dp (
		.clk(clk), .arst_n(arst_n), .item(in_data), .cmd(cmd), .status(status),
		.result(out_data)
	);

`include "dual_bank_priority_interrupt_controller_core_assert.svh"
	// An accepted transfer blocks further input until its result is built.
	`DBPIC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
	// A result is only loaded while no earlier result is still pending.
	`DBPIC_ASSERT_IMP(a_no_overwrite, cmd.finish, !out_valid || !out_stall)
	// The vector is either the idle code or a real source vector.
	`DBPIC_ASSERT_IMP(a_vector_range, out_valid,
		out_data.cpu_vector == VEC_NONE || out_data.cpu_vector >= VEC_BASE)
endmodule

/* sv/dbpic_ctrl.sv */
// Controller state machine that sequences one item through the datapath.
module dbpic_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output dbpic_pkg::dp_cmd_t  cmd,
	input  dbpic_pkg::dp_status_t status
);
	import dbpic_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       take;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign take = in_valid && (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load = take;
		cmd.scan_start = take;
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.finish = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (take) state_q <= ST_SCAN;
				ST_SCAN: if (status.scan_last) state_q <= ST_DONE;
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end
endmodule

/* sv/dbpic_datapath.sv */
// Register file, level memory, bus decode and source-serial priority scan of the controller.
module dbpic_datapath #(
	parameter int SOURCES_PER_BANK = dbpic_pkg::SRC_MAX,
	parameter int BANKS = dbpic_pkg::BANK_MAX
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dbpic_pkg::in_item_t   item,
	input  dbpic_pkg::dp_cmd_t    cmd,
	output dbpic_pkg::dp_status_t status,
	output dbpic_pkg::out_item_t  result
);
	import dbpic_pkg::*;

	logic [63:0] pend_q [2];
	logic [63:0] mask_q [2];
	logic [63:0] en_q   [2];
	logic [7:0]  lvl_mem [128];
	logic [7:0]  bvec_q [2];
	logic [7:0]  gvec_q;
	logic [31:0] rdata_q;
	logic        bad_q;
	logic [7:0]  lvl_rd_q;
	logic        lvl_sel_q;
	logic [6:0]  idx_q;
	logic [1:0]  act_s1;
	logic [7:0]  lv_s1 [2];
	logic [5:0]  src_s1;
	logic [1:0]  found_q;
	logic [7:0]  best_lv_q [2];
	logic [5:0]  best_src_q [2];
	out_item_t   result_q;

	logic        bank_ok;
	logic        ubit;
	logic [5:0]  n;
	logic        lvl_win;
	logic        level_ack;
	logic [31:0] rd;
	logic        bad;
	logic [5:0]  wsrc;
	logic        lbank;
	logic        src_ok_lvl;
	logic        src_ok_line;
	logic        lvl_we;
	logic        lvl_sel;
	logic [6:0]  addr_a;
	logic [6:0]  addr_b;
	logic [1:0]  act_rd;
	logic [1:0]  upd;

	assign ubit = item.unit[0];
	assign bank_ok = (item.unit[1] == 1'b0) && (int'(item.unit) < BANKS);
	assign n = item.offset[5:0];
	assign lvl_win = (item.offset[7:6] == 2'b01);
	assign src_ok_lvl = int'(n) < SOURCES_PER_BANK;
	assign level_ack = (item.offset >= 8'he4) && (item.offset[1:0] == 2'b00);
	assign wsrc = item.wdata[5:0];
	assign lbank = item.line[6];
	assign src_ok_line = (int'(lbank) < BANKS) && (int'(item.line[5:0]) < SOURCES_PER_BANK);
	assign lvl_we = cmd.load && (item.req_type == REQ_WRITE) && bank_ok && lvl_win
		&& src_ok_lvl;
	// A level byte whose enable bit is clear reads as zero, so the enable bit
	// stands in for a reset of the level memory.
	assign lvl_sel = (item.req_type == REQ_READ) && bank_ok && lvl_win && src_ok_lvl
		&& en_q[ubit][n];

	always_comb begin
		rd = '0;
		bad = 1'b0;
		if (item.req_type == REQ_READ) begin
			if (item.unit == UNIT_GLOBAL) begin
				if (item.offset == OFF_VECTOR) rd = {24'd0, gvec_q};
				else if (level_ack) bad = 1'b1;
			end else if (bank_ok) begin
				// Level bytes come from the memory read port.
				if (lvl_win) rd = '0;
				else if (item.offset == OFF_PEND_HI) rd = pend_q[ubit][63:32];
				else if (item.offset == OFF_PEND_LO) rd = pend_q[ubit][31:0];
				else if (item.offset == OFF_MASK_HI) rd = mask_q[ubit][63:32];
				else if (item.offset == OFF_MASK_LO) rd = mask_q[ubit][31:0];
				else if (item.offset == OFF_VECTOR) rd = {24'd0, bvec_q[ubit]};
				else if (level_ack) bad = 1'b1;
			end
		end else if (item.req_type == REQ_WRITE) begin
			if (item.unit == UNIT_GLOBAL) bad = 1'b1;
			else if (bank_ok) begin
				if (!(lvl_win || item.offset == OFF_PEND_HI || item.offset == OFF_PEND_LO
					|| item.offset == OFF_MASK_HI || item.offset == OFF_MASK_LO
					|| item.offset == OFF_SET_MASK || item.offset == OFF_CLR_MASK))
					bad = 1'b1;
			end
		end
	end

	// Scan: one source of each bank per step, read in the first stage and
	// compared in the second; ">=" lets higher sources win ties.
	assign addr_a = cmd.load ? {ubit, n} : {1'b0, idx_q[5:0]};
	assign addr_b = {1'b1, idx_q[5:0]};

	always_comb begin
		for (int b = 0; b < 2; b++) begin
			act_rd[b] = pend_q[b][idx_q[5:0]] && en_q[b][idx_q[5:0]]
				&& !mask_q[b][idx_q[5:0]] && (int'(idx_q) < SOURCES_PER_BANK)
				&& (b < BANKS);
			upd[b] = act_s1[b] && (!found_q[b] || lv_s1[b] >= best_lv_q[b]);
		end
	end

	assign status.scan_last = (int'(idx_q) == SOURCES_PER_BANK);

	logic [7:0] v0, v1;
	assign v0 = found_q[0] ? (VEC_BASE + {2'b00, best_src_q[0]}) : VEC_NONE;
	assign v1 = found_q[1] ? (VEC_BASE + 8'd64 + {2'b00, best_src_q[1]}) : VEC_NONE;

	logic [7:0] lv0_eff;
	logic [7:0] lv1_eff;
	logic       pick0;
	logic [7:0] fin_lv;
	logic [7:0] fin_vec;
	assign lv0_eff = found_q[0] ? best_lv_q[0] : 8'd0;
	assign lv1_eff = found_q[1] ? best_lv_q[1] : 8'd0;
	assign pick0 = (lv0_eff >= lv1_eff);
	assign fin_lv = pick0 ? lv0_eff : lv1_eff;
	assign fin_vec = pick0 ? v0 : v1;

	always_ff @(posedge clk) begin
		if (lvl_we) lvl_mem[{ubit, n}] <= item.wdata[7:0];
		if (cmd.load) lvl_rd_q <= lvl_mem[addr_a];
		if (cmd.scan_step) begin
			lv_s1[0] <= lvl_mem[addr_a];
			lv_s1[1] <= lvl_mem[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < 2; b++) begin
				pend_q[b] <= '0;
				mask_q[b] <= '1;
				en_q[b] <= '0;
				bvec_q[b] <= VEC_NONE;
			end
			gvec_q <= '0;
			idx_q <= '0;
			act_s1 <= '0;
			found_q <= '0;
		end else begin
			if (cmd.load) begin
				if (item.req_type == REQ_WRITE && bank_ok) begin
					if (lvl_win) begin
						if (src_ok_lvl) en_q[ubit][n] <= (item.wdata != '0);
					end else if (item.offset == OFF_MASK_HI)
						mask_q[ubit][63:32] <= item.wdata;
					else if (item.offset == OFF_MASK_LO)
						mask_q[ubit][31:0] <= item.wdata;
					else if (item.offset == OFF_SET_MASK) begin
						if (item.wdata[6]) mask_q[ubit] <= '1;
						else mask_q[ubit][wsrc] <= 1'b1;
					end else if (item.offset == OFF_CLR_MASK) begin
						if (item.wdata[6]) mask_q[ubit] <= '0;
						else mask_q[ubit][wsrc] <= 1'b0;
					end
				end else if (item.req_type == REQ_LINE && src_ok_line)
					pend_q[lbank][item.line[5:0]] <= item.line_level;
			end
			if (cmd.scan_start) begin
				idx_q <= '0;
				act_s1 <= '0;
				found_q <= '0;
			end else if (cmd.scan_step) begin
				act_s1 <= act_rd;
				src_s1 <= idx_q[5:0];
				for (int b = 0; b < 2; b++) begin
					if (upd[b]) begin
						found_q[b] <= 1'b1;
						best_lv_q[b] <= lv_s1[b];
						best_src_q[b] <= src_s1;
					end
				end
				if (!status.scan_last) idx_q <= idx_q + 7'd1;
			end
			if (cmd.finish) begin
				bvec_q[0] <= v0;
				bvec_q[1] <= v1;
				gvec_q <= fin_vec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rdata_q <= rd;
			bad_q <= bad;
			lvl_sel_q <= lvl_sel;
		end
		if (cmd.finish) begin
			result_q.rdata <= lvl_sel_q ? {24'd0, lvl_rd_q} : rdata_q;
			result_q.bad_access <= bad_q;
			result_q.cpu_level <= fin_lv;
			result_q.cpu_vector <= fin_vec;
		end
	end

	assign result = result_q;
endmodule

/* test/tb_dual_bank_priority_interrupt_controller_core.sv */
// Self-checking testbench for the two-bank vectored priority interrupt controller.
module tb_dual_bank_priority_interrupt_controller_core;
	timeunit 1ns;
	timeprecision 1ps;
	import dbpic_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;
	localparam logic [7:0] OFF_LEVEL_BASE = 8'h40;
	localparam logic [7:0] OFF_LEVEL_END = 8'h80;
	localparam logic [7:0] OFF_FORCE_HI = 8'h10;
	localparam logic [7:0] OFF_FORCE_LO = 8'h14;
	localparam logic [7:0] OFF_ACK_FIRST = 8'he4;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam logic [1:0] UNIT_ABSENT = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	out_item_t out_data;

	always #1 clk = ~clk;

	dual_bank_priority_interrupt_controller_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Shadow of the controller state, kept in step with accepted transfers.
	logic [63:0] pend_shadow [2];
	logic [63:0] mask_shadow [2];
	logic [63:0] enable_shadow [2];
	logic [7:0] level_shadow [128];
	logic [7:0] bank_vec_shadow [2];
	logic [7:0] global_vec_shadow;
	logic [7:0] win_level_shadow;

	out_item_t result_queue [$];
	int mismatches = 0;
	int idle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_receiver = 1'b0;

	function automatic void reset_shadow();
		for (int b = 0; b < 2; b++) begin
			pend_shadow[b] = '0;
			mask_shadow[b] = '1;
			enable_shadow[b] = '0;
			bank_vec_shadow[b] = VEC_NONE;
		end
		for (int i = 0; i < 128; i++)
			level_shadow[i] = '0;
		global_vec_shadow = '0;
		win_level_shadow = '0;
	endfunction

	function automatic bit is_ack_offset(logic [7:0] off);
		return off >= OFF_ACK_FIRST && off[1:0] == 2'b00;
	endfunction

	// Apply one item to the shadow state and return the result it must produce.
	function automatic out_item_t predict_controller(in_item_t it);
		out_item_t r;
		logic [63:0] act;
		int best, best_lv;
		int lv [2];
		int u, n;
		r = '0;
		u = int'(it.unit);
		n = int'(it.offset) - int'(OFF_LEVEL_BASE);
		if (it.req_type == REQ_READ) begin
			if (it.unit == UNIT_GLOBAL) begin
				if (it.offset == OFF_VECTOR) r.rdata = 32'(global_vec_shadow);
				else if (is_ack_offset(it.offset)) r.bad_access = 1'b1;
			end else if (u < 2) begin
				if (it.offset >= OFF_LEVEL_BASE && it.offset < OFF_LEVEL_END)
					r.rdata = 32'(level_shadow[u * 64 + n]);
				else if (it.offset == OFF_PEND_HI) r.rdata = pend_shadow[u][63:32];
				else if (it.offset == OFF_PEND_LO) r.rdata = pend_shadow[u][31:0];
				else if (it.offset == OFF_MASK_HI) r.rdata = mask_shadow[u][63:32];
				else if (it.offset == OFF_MASK_LO) r.rdata = mask_shadow[u][31:0];
				else if (it.offset == OFF_VECTOR) r.rdata = 32'(bank_vec_shadow[u]);
				else if (is_ack_offset(it.offset)) r.bad_access = 1'b1;
			end
		end else if (it.req_type == REQ_WRITE) begin
			if (it.unit == UNIT_GLOBAL) begin
				r.bad_access = 1'b1;
			end else if (u < 2) begin
				if (it.offset >= OFF_LEVEL_BASE && it.offset < OFF_LEVEL_END) begin
					level_shadow[u * 64 + n] = it.wdata[7:0];
					enable_shadow[u][n] = (it.wdata != 0);
				end else if (it.offset == OFF_PEND_HI || it.offset == OFF_PEND_LO) begin
				end else if (it.offset == OFF_MASK_HI) begin
					mask_shadow[u][63:32] = it.wdata;
				end else if (it.offset == OFF_MASK_LO) begin
					mask_shadow[u][31:0] = it.wdata;
				end else if (it.offset == OFF_SET_MASK) begin
					if (it.wdata[6]) mask_shadow[u] = '1;
					else mask_shadow[u][it.wdata[5:0]] = 1'b1;
				end else if (it.offset == OFF_CLR_MASK) begin
					if (it.wdata[6]) mask_shadow[u] = '0;
					else mask_shadow[u][it.wdata[5:0]] = 1'b0;
				end else begin
					r.bad_access = 1'b1;
				end
			end
		end else if (it.req_type == REQ_LINE) begin
			pend_shadow[it.line[6]][it.line[5:0]] = it.line_level;
		end
		// Rescan: highest level wins; on equal levels the higher source within a bank, bank 0 across banks.
		for (int b = 0; b < 2; b++) begin
			act = pend_shadow[b] & enable_shadow[b] & ~mask_shadow[b];
			best = -1;
			best_lv = 0;
			for (int i = 0; i < 64; i++)
				if (act[i] && int'(level_shadow[b * 64 + i]) >= best_lv) begin
					best_lv = int'(level_shadow[b * 64 + i]);
					best = i;
				end
			bank_vec_shadow[b] = (best < 0) ? VEC_NONE : VEC_BASE + 8'(64 * b + best);
			lv[b] = best_lv;
		end
		if (lv[0] >= lv[1]) begin
			win_level_shadow = 8'(lv[0]);
			global_vec_shadow = bank_vec_shadow[0];
		end else begin
			win_level_shadow = 8'(lv[1]);
			global_vec_shadow = bank_vec_shadow[1];
		end
		r.cpu_level = win_level_shadow;
		r.cpu_vector = global_vec_shadow;
		return r;
	endfunction

	// Offer one item, with an optional random gap first, and wait for its transfer.
	task automatic send_item(in_item_t it);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		result_queue.push_back(predict_controller(it));
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
	endtask

	function automatic in_item_t make_item(logic [1:0] req, logic [1:0] unit,
			logic [7:0] off, logic [31:0] wdata);
		in_item_t it;
		it.req_type = req;
		it.unit = unit;
		it.offset = off;
		it.wdata = wdata;
		it.line = 7'($urandom);
		it.line_level = 1'($urandom);
		return it;
	endfunction

	function automatic in_item_t line_item(logic [6:0] ln, logic lvl);
		in_item_t it;
		it = '0;
		it.req_type = REQ_LINE;
		it.unit = 2'($urandom);
		it.offset = 8'($urandom);
		it.wdata = $urandom;
		it.line = ln;
		it.line_level = lvl;
		return it;
	endfunction

	task automatic wait_drained();
		go_idle();
		while (result_queue.size() != 0) @(posedge clk);
	endtask

	// Directed checks of the register map and the special cases.
	task automatic test_register_map();
		send_item(make_item(REQ_READ, UNIT_GLOBAL, OFF_VECTOR, '0));
		send_item(make_item(REQ_WRITE, 2'd0, OFF_LEVEL_BASE + 8'd5, 32'h0000_00ff));
		send_item(make_item(REQ_WRITE, 2'd0, OFF_CLR_MASK, 32'h0000_0040));
		send_item(line_item(7'd5, 1'b1));
		send_item(make_item(REQ_WRITE, 2'd1, OFF_LEVEL_BASE + 8'd63, 32'h0000_00ff));
		send_item(make_item(REQ_WRITE, 2'd1, OFF_CLR_MASK, 32'h0000_003f));
		send_item(line_item(7'd127, 1'b1));
		send_item(make_item(REQ_READ, 2'd1, OFF_VECTOR, '0));
		send_item(make_item(REQ_READ, UNIT_GLOBAL, OFF_VECTOR, '0));
		send_item(make_item(REQ_WRITE, 2'd0, OFF_LEVEL_BASE + 8'd9, 32'hffff_ff00));
		send_item(line_item(7'd9, 1'b1));
		send_item(make_item(REQ_WRITE, 2'd0, OFF_MASK_HI, 32'hffff_ffff));
		send_item(make_item(REQ_WRITE, 2'd0, OFF_MASK_LO, 32'h0000_0000));
		send_item(make_item(REQ_READ, 2'd0, OFF_MASK_LO, '0));
		send_item(make_item(REQ_READ, 2'd0, OFF_PEND_LO, '0));
		send_item(make_item(REQ_WRITE, 2'd0, OFF_PEND_HI, 32'hffff_ffff));
		send_item(make_item(REQ_WRITE, 2'd0, OFF_FORCE_HI, 32'h1));
		send_item(make_item(REQ_READ, 2'd1, OFF_FORCE_LO, '0));
		send_item(make_item(REQ_READ, 2'd0, 8'hfc, '0));
		send_item(make_item(REQ_READ, UNIT_GLOBAL, OFF_ACK_FIRST, '0));
		send_item(make_item(REQ_WRITE, UNIT_GLOBAL, OFF_VECTOR, 32'h5));
		send_item(make_item(REQ_WRITE, UNIT_ABSENT, OFF_MASK_LO, 32'h0));
		send_item(make_item(REQ_READ, UNIT_ABSENT, OFF_MASK_LO, '0));
		send_item(make_item(REQ_UNKNOWN, 2'd0, OFF_SET_MASK, 32'h40));
		send_item(make_item(REQ_WRITE, 2'd1, OFF_SET_MASK, 32'h40));
		wait_drained();
	endtask

	function automatic logic [7:0] pick_offset();
		case ($urandom_range(9, 0))
			0: return OFF_PEND_HI;
			1: return OFF_PEND_LO;
			2: return OFF_MASK_HI;
			3: return OFF_MASK_LO;
			4: return OFF_SET_MASK;
			5: return OFF_CLR_MASK;
			6: return OFF_VECTOR;
			7: return 8'($urandom);
			default: return OFF_LEVEL_BASE + 8'($urandom_range(63, 0));
		endcase
	endfunction

	// Random mix of line changes, register writes, reads and raw random items.
	task automatic test_random_traffic(int count);
		in_item_t it;
		logic [31:0] wd;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(9, 0))
				0, 1, 2: it = line_item(7'($urandom), 1'($urandom_range(3, 0) != 0));
				3, 4, 5: begin
					wd = $urandom_range(3, 0) == 0 ? $urandom : 32'($urandom_range(255, 0));
					it = make_item(REQ_WRITE, 2'($urandom_range(1, 0)), pick_offset(), wd);
				end
				9: it = in_item_t'({$urandom, $urandom});
				default: it = make_item(REQ_READ, 2'($urandom_range(2, 0)),
					$urandom_range(3, 0) == 0 ? OFF_VECTOR : pick_offset(), '0);
			endcase
			send_item(it);
		end
		wait_drained();
	endtask

	// The receiver holds off long enough that the input side must stall.
	task automatic test_backpressure();
		hold_receiver = 1'b1;
		for (int k = 0; k < 6; k++)
			send_item(line_item(7'($urandom), 1'b1));
		hold_receiver = 1'b0;
		wait_drained();
	endtask

	// Output channel: random stalls and the long hold used for back-pressure.
	initial begin : receiver
		int held;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_receiver && held < HOLD_CYCLES) begin
				held++;
				out_stall <= 1'b1;
			end else begin
				if (!hold_receiver) held = 0;
				out_stall <= (recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
			end
		end
	end

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (result_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", out_data);
			end else begin
				want = result_queue.pop_front();
				if (out_data.rdata !== want.rdata || out_data.bad_access !== want.bad_access
						|| out_data.cpu_level !== want.cpu_level
						|| out_data.cpu_vector !== want.cpu_vector) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h got %h", want, out_data);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
		else idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		reset_shadow();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_map();
		send_idle_pct = 23;
		recv_idle_pct = 79;
		test_random_traffic(340);
		test_backpressure();
		send_idle_pct = 79;
		recv_idle_pct = 23;
		test_random_traffic(340);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(340);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && result_queue.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
